>>> rtl/rbst_pkg.sv
// ----------------------------------------------------------------------------
// rbst_pkg
// Widths, stage count and register indexes for the ray/box slab test core.
// ----------------------------------------------------------------------------
package rbst_pkg;

    localparam int COORD_WIDTH = 32;                  // signed coordinate width
    localparam int FRAC_BITS   = 16;                  // fraction bits
    localparam int EXT_WIDTH   = COORD_WIDTH - 1;     // unsigned extent width
    localparam int NUM_AXES    = 3;

    // 2*center -/+ extent - 2*origin, doubled units; spans a bit above 2^33
    localparam int DIFF_W    = COORD_WIDTH + 3;
    localparam int PROD_W    = DIFF_W + COORD_WIDTH;
    localparam int SHIFT_AMT = FRAC_BITS + 1;         // undo doubling and Q scale
    localparam int SH_W      = PROD_W - SHIFT_AMT;

    localparam int NUM_STAGES = 6;

    localparam int IN_FIELDS   = 2 * NUM_AXES;
    localparam int IN_TDATA_W  = ((IN_FIELDS * COORD_WIDTH + 7) / 8) * 8;
    localparam int OUT_TDATA_W = 8;
    localparam int CFG_IDX_W   = 3;

    localparam logic signed [COORD_WIDTH-1:0] POS_LIMIT = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    localparam logic signed [COORD_WIDTH-1:0] NEG_LIMIT = {1'b1, {(COORD_WIDTH-1){1'b0}}};

    typedef logic [CFG_IDX_W-1:0] cfg_index_t;

    localparam cfg_index_t CFG_CENTER_X = 3'd0;
    localparam cfg_index_t CFG_CENTER_Y = 3'd1;
    localparam cfg_index_t CFG_CENTER_Z = 3'd2;
    localparam cfg_index_t CFG_EXTENT_X = 3'd3;
    localparam cfg_index_t CFG_EXTENT_Y = 3'd4;
    localparam cfg_index_t CFG_EXTENT_Z = 3'd5;

    typedef logic signed [COORD_WIDTH-1:0] coord_t;
    typedef logic [EXT_WIDTH-1:0]          extent_t;
    typedef logic signed [DIFF_W-1:0]      diff_t;
    typedef logic signed [PROD_W-1:0]      prod_t;

endpackage

>>> rtl/ray_box_slab_test_core.sv
// ----------------------------------------------------------------------------
// ray_box_slab_test_core
// Ray versus axis-aligned box hit test (slab method), signed Q16.16.
// ----------------------------------------------------------------------------
// Usage:
//   Box center and full size are loaded through the cfg_* write channel
//   (index 0..2 center x/y/z, 3..5 extent x/y/z; other indexes ignored).
//   cfg_ready is always high. Write the box only while no ray is in flight.
//   One ray item enters on s_axis (origin x/y/z, inverse direction x/y/z);
//   one result item with the hit flag leaves on m_axis for every ray.
// Stages / throughput:
//   Six register stages: plane offsets, products, shift/saturate, per-axis
//   near/far, slab merge, final compare. An accepted item passes through
//   them in that order; m_tvalid rises once it is in the output register.
//   One item per cycle sustained while m_tready stays high; the 35x32
//   products of stage 2 are the deepest logic.
// Reset:
//   aresetn low (synchronous) empties the pipeline and clears the box to
//   center 0, extent 0.
// Stall:
//   Each stage holds its item while the one downstream is full and stalled.
//   Empty stages still fill, so s_tready stays high until all six stages hold
//   items and m_tready is low. Nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module ray_box_slab_test_core
    import rbst_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,

    // config write channel
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [COORD_WIDTH-1:0] cfg_data,

    // ray items in
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // from bit 0: origin_x, origin_y, origin_z, inv_dir_x, inv_dir_y, inv_dir_z
    input  logic [IN_TDATA_W-1:0]  s_tdata,

    // result items out
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // from bit 0: hit, then zero fill
    output logic [OUT_TDATA_W-1:0] m_tdata
);

    // ---------------- box registers ----------------
    coord_t  center_reg [NUM_AXES];
    extent_t extent_reg [NUM_AXES];

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < NUM_AXES; k++) begin
                center_reg[k] <= '0;
                extent_reg[k] <= '0;
            end
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_CENTER_X: center_reg[0] <= cfg_data;
                CFG_CENTER_Y: center_reg[1] <= cfg_data;
                CFG_CENTER_Z: center_reg[2] <= cfg_data;
                CFG_EXTENT_X: extent_reg[0] <= cfg_data[EXT_WIDTH-1:0];
                CFG_EXTENT_Y: extent_reg[1] <= cfg_data[EXT_WIDTH-1:0];
                CFG_EXTENT_Z: extent_reg[2] <= cfg_data[EXT_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- pipeline control ----------------
    // stage_en[k]: stage k loads this cycle (it is empty or its item moves on)
    logic [NUM_STAGES-1:0] valid_reg;
    logic [NUM_STAGES-1:0] stage_en;

    always_comb begin
        stage_en[NUM_STAGES-1] = !valid_reg[NUM_STAGES-1] || m_tready;
        for (int k = NUM_STAGES - 2; k >= 0; k--) begin
            stage_en[k] = !valid_reg[k] || stage_en[k+1];
        end
    end

    assign s_tready = stage_en[0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            if (stage_en[0]) begin
                valid_reg[0] <= s_tvalid;
            end
            for (int k = 1; k < NUM_STAGES; k++) begin
                if (stage_en[k]) begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
        end
    end

    // ---------------- stage 1: plane offsets (doubled units) ----------------
    diff_t  dlo_reg  [NUM_AXES];
    diff_t  dhi_reg  [NUM_AXES];
    coord_t inv1_reg [NUM_AXES];

    coord_t org_in [NUM_AXES];
    coord_t inv_in [NUM_AXES];
    diff_t  dlo_next [NUM_AXES];
    diff_t  dhi_next [NUM_AXES];

    always_comb begin
        for (int k = 0; k < NUM_AXES; k++) begin
            org_in[k] = s_tdata[k*COORD_WIDTH +: COORD_WIDTH];
            inv_in[k] = s_tdata[(NUM_AXES+k)*COORD_WIDTH +: COORD_WIDTH];
            // 2c - 2o, then -/+ extent
            dlo_next[k] = {{(DIFF_W-COORD_WIDTH-1){center_reg[k][COORD_WIDTH-1]}},
                           center_reg[k], 1'b0}
                        - {{(DIFF_W-COORD_WIDTH-1){org_in[k][COORD_WIDTH-1]}},
                           org_in[k], 1'b0}
                        - {{(DIFF_W-EXT_WIDTH){1'b0}}, extent_reg[k]};
            dhi_next[k] = {{(DIFF_W-COORD_WIDTH-1){center_reg[k][COORD_WIDTH-1]}},
                           center_reg[k], 1'b0}
                        - {{(DIFF_W-COORD_WIDTH-1){org_in[k][COORD_WIDTH-1]}},
                           org_in[k], 1'b0}
                        + {{(DIFF_W-EXT_WIDTH){1'b0}}, extent_reg[k]};
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_en[0]) begin
            for (int k = 0; k < NUM_AXES; k++) begin
                dlo_reg[k]  <= dlo_next[k];
                dhi_reg[k]  <= dhi_next[k];
                inv1_reg[k] <= inv_in[k];
            end
        end
    end

    // ---------------- stage 2: exact products ----------------
    prod_t plo_reg [NUM_AXES];
    prod_t phi_reg [NUM_AXES];

    always_ff @(posedge aclk) begin
        if (stage_en[1]) begin
            for (int k = 0; k < NUM_AXES; k++) begin
                plo_reg[k] <= dlo_reg[k] * inv1_reg[k];
                phi_reg[k] <= dhi_reg[k] * inv1_reg[k];
            end
        end
    end

    // ---------------- stage 3: floor shift and saturate ----------------
    function automatic coord_t shift_sat(input prod_t p);
        logic [SH_W-1:0] s;
        logic            ovf;
        s   = p[PROD_W-1:SHIFT_AMT];
        ovf = !((&s[SH_W-1:COORD_WIDTH-1]) || !(|s[SH_W-1:COORD_WIDTH-1]));
        if (!ovf) begin
            return s[COORD_WIDTH-1:0];
        end else if (s[SH_W-1]) begin
            return NEG_LIMIT;
        end else begin
            return POS_LIMIT;
        end
    endfunction

    coord_t t1_reg [NUM_AXES];
    coord_t t2_reg [NUM_AXES];

    always_ff @(posedge aclk) begin
        if (stage_en[2]) begin
            for (int k = 0; k < NUM_AXES; k++) begin
                t1_reg[k] <= shift_sat(plo_reg[k]);
                t2_reg[k] <= shift_sat(phi_reg[k]);
            end
        end
    end

    // ---------------- stage 4: per-axis near / far ----------------
    coord_t near_reg [NUM_AXES];
    coord_t far_reg  [NUM_AXES];

    always_ff @(posedge aclk) begin
        if (stage_en[3]) begin
            for (int k = 0; k < NUM_AXES; k++) begin
                if (t1_reg[k] < t2_reg[k]) begin
                    near_reg[k] <= t1_reg[k];
                    far_reg[k]  <= t2_reg[k];
                end else begin
                    near_reg[k] <= t2_reg[k];
                    far_reg[k]  <= t1_reg[k];
                end
            end
        end
    end

    // ---------------- stage 5: slab merge ----------------
    coord_t tmin_reg, tmax_reg;
    coord_t tmin_next, tmax_next;

    always_comb begin
        tmin_next = near_reg[0];
        tmax_next = far_reg[0];
        for (int k = 1; k < NUM_AXES; k++) begin
            if (near_reg[k] > tmin_next) tmin_next = near_reg[k];
            if (far_reg[k] < tmax_next)  tmax_next = far_reg[k];
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_en[4]) begin
            tmin_reg <= tmin_next;
            tmax_reg <= tmax_next;
        end
    end

    // ---------------- stage 6: hit flag (output register) ----------------
    coord_t floor0;
    logic   hit_reg;

    assign floor0 = (tmin_reg > coord_t'(0)) ? tmin_reg : coord_t'(0);

    always_ff @(posedge aclk) begin
        if (stage_en[5]) begin
            hit_reg <= (tmax_reg > floor0);
        end
    end

    assign m_tvalid = valid_reg[NUM_STAGES-1];
    assign m_tdata  = {{(OUT_TDATA_W-1){1'b0}}, hit_reg};

    // ---------------- assertions ----------------
    // any empty stage means the input side can take an item
    a_ready_when_room: assert property (@(posedge aclk) disable iff (!aresetn)
        !(&valid_reg) |-> s_tready)
        else $error("s_tready low with an empty stage");

    // output taken means the whole pipe advances
    a_flow_through: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready) |-> s_tready)
        else $error("pipe stalled while output drains");

    // accepted item lands in stage 1
    a_accept_lands: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> valid_reg[0])
        else $error("accepted item lost at stage 1");

    // per-axis ordering
    a_near_le_far: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg[3] |-> ((near_reg[0] <= far_reg[0]) && (near_reg[1] <= far_reg[1])
                          && (near_reg[2] <= far_reg[2])))
        else $error("near distance above far distance");

endmodule

>>> tb/ray_slab_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ray_slab_checker
// Watches the config, ray and result channels of the slab test core. Keeps
// its own copy of the box, predicts the hit flag of every accepted ray, and
// compares each result item against the oldest prediction.
// ----------------------------------------------------------------------------
module ray_slab_checker
    import rbst_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_valid,
    input  logic                   cfg_ready,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [COORD_WIDTH-1:0] cfg_data,
    input  logic                   s_tvalid,
    input  logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    input  logic                   m_tvalid,
    input  logic                   m_tready,
    input  logic [OUT_TDATA_W-1:0] m_tdata,
    output int                     fail_count,
    output int                     pending
);

    localparam logic signed [127:0] DIST_MAX = POS_LIMIT;
    localparam logic signed [127:0] DIST_MIN = NEG_LIMIT;

    typedef struct {
        int seq;
        bit hit;
    } hit_entry_t;

    coord_t     box_center [NUM_AXES];
    extent_t    box_extent [NUM_AXES];
    hit_entry_t hit_q [$];
    int         ray_seq  = 0;
    int         errors   = 0;
    int         waiting  = 0;

    assign fail_count = errors;
    assign pending    = waiting;

    task automatic flag_mismatch(input string what);
        $display("[%0t] MISMATCH: %s", $realtime, what);
        errors++;
    endtask

    // (offset * inv) / 2^(FRAC+1), floored, clamped to the coordinate range
    function automatic coord_t plane_dist(input logic signed [63:0] offset,
                                          input coord_t inv);
        logic signed [127:0] wide;
        wide = offset * inv;
        wide = wide >>> SHIFT_AMT;
        if (wide > DIST_MAX)
            return POS_LIMIT;
        if (wide < DIST_MIN)
            return NEG_LIMIT;
        return wide[COORD_WIDTH-1:0];
    endfunction

    function automatic bit ray_hits(input logic [IN_TDATA_W-1:0] ray);
        coord_t              org, inv, t_lo, t_hi, t_enter, t_exit;
        logic signed [63:0]  c2, o2, ext;
        t_enter = NEG_LIMIT;
        t_exit  = POS_LIMIT;
        for (int a = 0; a < NUM_AXES; a++) begin
            org = ray[a*COORD_WIDTH +: COORD_WIDTH];
            inv = ray[(a+NUM_AXES)*COORD_WIDTH +: COORD_WIDTH];
            c2  = box_center[a];
            c2  = c2 <<< 1;
            o2  = org;
            o2  = o2 <<< 1;
            ext = {33'd0, box_extent[a]};
            t_lo = plane_dist(c2 - ext - o2, inv);
            t_hi = plane_dist(c2 + ext - o2, inv);
            if (t_lo > t_hi) begin
                org  = t_lo;
                t_lo = t_hi;
                t_hi = org;
            end
            if (t_lo > t_enter)
                t_enter = t_lo;
            if (t_hi < t_exit)
                t_exit = t_hi;
        end
        if (t_enter < 0)
            t_enter = '0;
        return t_exit > t_enter;
    endfunction

    always @(posedge aclk) begin
        hit_entry_t head;
        if (!aresetn) begin
            for (int a = 0; a < NUM_AXES; a++) begin
                box_center[a] = '0;
                box_extent[a] = '0;
            end
            hit_q.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                if (hit_q.size() == 0) begin
                    flag_mismatch($sformatf("result hit=%0b with no ray outstanding",
                                            m_tdata[0]));
                end else begin
                    head = hit_q.pop_front();
                    if (m_tdata[0] !== head.hit)
                        flag_mismatch($sformatf("ray %0d: hit %b, predicted %0b",
                                                head.seq, m_tdata[0], head.hit));
                    if (m_tdata[OUT_TDATA_W-1:1] !== '0)
                        flag_mismatch($sformatf("ray %0d: fill bits %b not zero",
                                                head.seq, m_tdata[OUT_TDATA_W-1:1]));
                end
            end
            if (s_tvalid && s_tready) begin
                hit_q.push_back('{ray_seq, ray_hits(s_tdata)});
                ray_seq++;
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_CENTER_X: box_center[0] = cfg_data;
                    CFG_CENTER_Y: box_center[1] = cfg_data;
                    CFG_CENTER_Z: box_center[2] = cfg_data;
                    CFG_EXTENT_X: box_extent[0] = cfg_data[EXT_WIDTH-1:0];
                    CFG_EXTENT_Y: box_extent[1] = cfg_data[EXT_WIDTH-1:0];
                    CFG_EXTENT_Z: box_extent[2] = cfg_data[EXT_WIDTH-1:0];
                    default: ;
                endcase
            end
        end
        waiting = hit_q.size();
    end

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the ray/box slab test core. Loads a series of
// boxes (reset, unit, degenerate, saturating corners, odd slivers, random),
// fires directed and random rays at each, and leaves all checking to the
// ray_slab_checker instance that sits beside the core.
// ----------------------------------------------------------------------------
module testbench;
    import rbst_pkg::*;

    // indexes the core does not decode; writes to them must be ignored
    localparam cfg_index_t CFG_SPARE_A = 3'd6;
    localparam cfg_index_t CFG_SPARE_B = 3'd7;

    localparam coord_t ONE  = 32'h0001_0000;   // 1.0 in Q16.16
    localparam coord_t FIVE = 32'h0005_0000;   // 5.0

    localparam int ITEMS_PER_PHASE = 150;
    localparam int HOLD_CYCLES     = 64;       // long sink stall, >> pipeline depth

    typedef enum {BOX_UNIT, BOX_EMPTY, BOX_TOP, BOX_BOTTOM, BOX_SLIVER, BOX_RANDOM}
        box_kind_t;
    typedef enum {SINK_OPEN, SINK_COIN, SINK_SLOW, SINK_PULSE} sink_mode_t;

    logic                   aclk = 1'b0;
    logic                   aresetn;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [COORD_WIDTH-1:0] cfg_data;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;    // origin x/y/z, then inv_dir x/y/z, from bit 0
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;    // hit, then zero fill, from bit 0

    int fail_count;
    int pending;

    // sender pacing and the long-stall handshake with the sink process
    int burst_left = 0;
    int gap        = 0;
    int hold_req   = 0;
    int hold_done  = 0;

    coord_t    aim_center [NUM_AXES];   // rays are aimed around the current box
    box_kind_t phase_plan [0:7] = '{BOX_EMPTY, BOX_TOP, BOX_RANDOM, BOX_BOTTOM,
                                    BOX_SLIVER, BOX_RANDOM, BOX_UNIT, BOX_RANDOM};

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    ray_box_slab_test_core u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    ray_slab_checker u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .fail_count (fail_count),
        .pending    (pending)
    );

    function automatic logic [IN_TDATA_W-1:0] make_ray(input coord_t ox, oy, oz,
                                                       input coord_t ix, iy, iz);
        return {iz, iy, ix, oz, oy, ox};
    endfunction

    // Mostly rays launched near the box and pointed at it, with some zero,
    // saturated and raw reciprocals mixed in; one in ten is pure noise.
    function automatic logic [IN_TDATA_W-1:0] random_ray();
        coord_t org [NUM_AXES];
        coord_t inv [NUM_AXES];
        coord_t mag;
        if ($urandom_range(0, 9) == 0)
            return {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        for (int a = 0; a < NUM_AXES; a++) begin
            org[a] = aim_center[a] + $urandom_range(0, 32'h80_0000) - 32'h40_0000;
            case ($urandom_range(0, 15))
                0: inv[a] = '0;
                1: inv[a] = POS_LIMIT;
                2: inv[a] = NEG_LIMIT;
                3: inv[a] = $urandom;
                default: begin
                    mag    = $urandom_range(32'h2000, 32'h8_0000);
                    inv[a] = (aim_center[a] < org[a]) ? -mag : mag;
                    if ($urandom_range(0, 3) == 0)
                        inv[a] = -inv[a];
                end
            endcase
        end
        return make_ray(org[0], org[1], org[2], inv[0], inv[1], inv[2]);
    endfunction

    // Called at a falling edge, returns at a falling edge. When paced, the
    // sender runs in bursts of random length separated by random gaps.
    task automatic offer(input logic [IN_TDATA_W-1:0] ray, input bit paced);
        s_tdata  <= ray;
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
        if (paced) begin
            if (burst_left > 0) begin
                burst_left--;
            end else begin
                burst_left = $urandom_range(0, 40);
                gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                if (gap > 0) begin
                    s_tvalid <= 1'b0;
                    repeat (gap) @(negedge aclk);
                end
            end
        end
    endtask

    // stop offering until every predicted result is back, then let the
    // pipeline settle
    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (NUM_STAGES) @(negedge aclk);
    endtask

    task automatic cfg_write(input cfg_index_t idx, input logic [COORD_WIDTH-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    // Sliver and random extent words carry random junk in bit 31 (the top box sets it) where the core must mask it.
    task automatic load_box(input box_kind_t kind);
        logic [COORD_WIDTH-1:0] ext_word [NUM_AXES];
        for (int a = 0; a < NUM_AXES; a++) begin
            case (kind)
                BOX_UNIT: begin
                    aim_center[a] = '0;
                    ext_word[a]   = 32'h0002_0000;
                end
                BOX_EMPTY: begin
                    aim_center[a] = '0;
                    ext_word[a]   = '0;
                end
                BOX_TOP: begin
                    aim_center[a] = POS_LIMIT;
                    ext_word[a]   = 32'hFFFF_FFFF;
                end
                BOX_BOTTOM: begin
                    aim_center[a] = NEG_LIMIT;
                    ext_word[a]   = 32'h7FFF_FFFF;
                end
                BOX_SLIVER: begin
                    // odd extents in the last bit: half a LSB per side
                    aim_center[a]   = $urandom_range(0, 32'h8_0000) - 32'h4_0000;
                    ext_word[a]     = 2 * $urandom_range(0, 3) + 1;
                    ext_word[a][31] = $urandom_range(0, 1);
                end
                default: begin
                    aim_center[a]   = $urandom_range(0, 32'h200_0000) - 32'h100_0000;
                    ext_word[a]     = $urandom_range(32'h100, 32'h100_0000);
                    ext_word[a][31] = $urandom_range(0, 1);
                end
            endcase
        end
        cfg_write(CFG_CENTER_X, aim_center[0]);
        cfg_write(CFG_CENTER_Y, aim_center[1]);
        cfg_write(CFG_CENTER_Z, aim_center[2]);
        cfg_write(CFG_EXTENT_X, ext_word[0]);
        cfg_write(CFG_EXTENT_Y, ext_word[1]);
        cfg_write(CFG_EXTENT_Z, ext_word[2]);
        cfg_write($urandom_range(0, 1) ? CFG_SPARE_A : CFG_SPARE_B, $urandom);
        cfg_valid <= 1'b0;
    endtask

    // Result sink: switches between always-ready, coin-flip, mostly-stalled and
    // periodic-pulse stretches. On request (hold_req) it stalls with m_tready low, then acks via hold_done.
    initial begin : sink
        sink_mode_t mode;
        int         mode_left;
        m_tready  = 1'b0;
        mode      = SINK_OPEN;
        mode_left = 0;
        forever begin
            @(negedge aclk);
            if (hold_done != hold_req) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge aclk);
                hold_done++;
            end else begin
                if (mode_left == 0) begin
                    mode      = sink_mode_t'($urandom_range(0, 3));
                    mode_left = $urandom_range(16, 160);
                end
                mode_left--;
                case (mode)
                    SINK_OPEN: m_tready <= 1'b1;
                    SINK_COIN: m_tready <= $urandom_range(0, 1);
                    SINK_SLOW: m_tready <= ($urandom_range(0, 3) == 0);
                    default:   m_tready <= (mode_left % 3 == 0);
                endcase
            end
        end
    end

    // Hard stop in case the core hangs.
    initial begin
        #5_000_000;
        $display("Regression FAIL");
        $finish;
    end

    initial begin : stimulus
        aresetn   = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        for (int a = 0; a < NUM_AXES; a++)
            aim_center[a] = '0;

        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // box straight out of reset: zero size at the origin
        offer(make_ray(-FIVE, '0, '0, ONE, POS_LIMIT, POS_LIMIT), 1'b1);
        offer(make_ray('0, '0, '0, ONE, ONE, ONE), 1'b1);
        drain();

        // Directed rays against the unit box (center 0, full size 2.0).
        // Zero reciprocals in y/z stand in for a ray parallel to those slabs;
        // saturated reciprocals stand in for the same with saturated distances.
        load_box(BOX_UNIT);
        offer(make_ray(-FIVE, '0, '0, ONE, POS_LIMIT, POS_LIMIT), 1'b1);   // head-on
        offer(make_ray(-FIVE, '0, '0, -ONE, POS_LIMIT, POS_LIMIT), 1'b1);  // box behind
        offer(make_ray(FIVE, '0, '0, -ONE, NEG_LIMIT, NEG_LIMIT), 1'b1);   // from +x side
        offer(make_ray(FIVE, '0, '0, ONE, POS_LIMIT, POS_LIMIT), 1'b1);    // moving away
        offer(make_ray('0, '0, '0, ONE, ONE, ONE), 1'b1);                  // from inside
        offer(make_ray('0, '0, '0, '0, '0, '0), 1'b1);                     // all zero
        offer(make_ray(-FIVE, '0, '0, '0, '0, '0), 1'b1);                  // zero reciprocal
        offer(make_ray(-FIVE, ONE, '0, ONE, POS_LIMIT, POS_LIMIT), 1'b1);  // grazes y face
        offer(make_ray(-FIVE, ONE + 1, '0, ONE, POS_LIMIT, POS_LIMIT), 1'b1); // just outside
        offer(make_ray(-FIVE, -FIVE, -FIVE, ONE, ONE, ONE), 1'b1);         // diagonal
        offer(make_ray(POS_LIMIT, POS_LIMIT, POS_LIMIT,
                       POS_LIMIT, POS_LIMIT, POS_LIMIT), 1'b1);
        offer(make_ray(NEG_LIMIT, NEG_LIMIT, NEG_LIMIT,
                       NEG_LIMIT, NEG_LIMIT, NEG_LIMIT), 1'b1);
        offer(make_ray(POS_LIMIT, POS_LIMIT, POS_LIMIT,
                       NEG_LIMIT, NEG_LIMIT, NEG_LIMIT), 1'b1);
        offer(make_ray(NEG_LIMIT, NEG_LIMIT, NEG_LIMIT,
                       POS_LIMIT, POS_LIMIT, POS_LIMIT), 1'b1);
        offer(make_ray('1, '1, '1, '1, '1, '1), 1'b1);
        offer(make_ray(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555,
                       32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA), 1'b1);

        // Random phases, one box each; the box only changes once the
        // pipeline is empty.
        for (int p = 0; p < 8; p++) begin
            drain();
            load_box(phase_plan[p]);
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (p == 2 && n == 40) begin
                    // sink stops for a long stretch while rays keep coming:
                    // the pipeline fills and must back-pressure the input
                    hold_req++;
                    repeat (32) offer(random_ray(), 1'b0);
                end
                if (p == 5 && n == 75)
                    drain();
                offer(random_ray(), 1'b1);
            end
        end

        drain();
        repeat (4 * NUM_STAGES) @(negedge aclk);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

>>> filelist.f
rtl/rbst_pkg.sv
rtl/ray_box_slab_test_core.sv
tb/ray_slab_checker.sv
tb/testbench.sv
